// ===== rtl/sorted_list_insert_delete_rank_defines.svh =====
// assertion macros for the sorted list block
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef SORTED_LIST_INSERT_DELETE_RANK_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_RANK_DEFINES_SVH

`ifndef SYNTHESIS
`define SLDR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sldr implication check failed");
`define SLDR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sldr next-cycle check failed");
`else
`define SLDR_ASSERT_IMPL(lbl, ante, cons)
`define SLDR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/sldr_pkg.sv =====
// types and status codes for the sorted list block
// no dependencies
`timescale 1ns / 1ps

package sldr_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned RANK_W  = 4;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned COUNT_W = 5;

    localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_RANK = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_MOVE = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

endpackage

// ===== rtl/sldr_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module sldr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sorted_list_insert_delete_rank.sv =====
// sorted list with insert by value and delete by rank from the largest
// depends on sldr_pkg, sldr_ram and sorted_list_insert_delete_rank_defines.svh
//
// usage:
//   input channel i_in_valid / o_in_ready carries one item: i_func selects
//   insert of i_new_value (0) or delete of the entry at i_rank counted from
//   the largest (1). output channel o_out_valid / i_out_ready returns one
//   result per item: o_status (done, rank not present, store full) and
//   o_entry_count, the number of stored values after the item, low 5 bits.
//   values sit in ascending order in one ram; an insert walks down from the
//   top, moving each entry that is not smaller up by one slot, and a delete
//   walks up from the removed slot, moving entries down. each moved entry
//   costs an S_STEP state (registered ram read), then an S_MOVE state
//   (compare and write back). a rejected item goes from idle straight to
//   S_FIN; an accepted one loops through S_STEP and S_MOVE until its slot
//   is done, then S_FIN loads the result into the output register.
//   one item is worked on at a time; o_in_ready is high only when idle,
//   so the next item can be taken in the same cycle the result is presented.
//   a finished result waits in the output register while the receiver
//   stalls; a later item then holds the sequencer in S_FIN until it drains.
//   reset empties the store at once, no clearing pass is needed.
`timescale 1ns / 1ps
`include "sorted_list_insert_delete_rank_defines.svh"

module sorted_list_insert_delete_rank
    import sldr_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_func,
    input  logic signed [VALUE_W-1:0] i_new_value,
    input  logic [RANK_W-1:0]         i_rank,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [STAT_W-1:0]         o_status,
    output logic [COUNT_W-1:0]        o_entry_count
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned XW = CW + RANK_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_ptr, n_ptr;
    logic                       r_func, n_func;
    logic signed [VALUE_W-1:0]  r_val, n_val;
    logic [STAT_W-1:0]          r_stat, n_stat;
    logic                       r_out_valid, n_out_valid;
    logic [STAT_W-1:0]          r_o_status, n_o_status;
    logic [COUNT_W-1:0]         r_o_count, n_o_count;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [VALUE_W-1:0]         ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [VALUE_W-1:0]         ram_rdata;

    logic [CW-1:0]              ptr_dn, ptr_up;
    logic                       rd_ge;
    logic [XW-1:0]              cnt_x, rank_x, pos_x;
    logic [CW+COUNT_W-1:0]      cnt_o;
    logic                       in_acc;

    sldr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared step unit: pointer up/down and the one signed compare
    assign ptr_dn = r_ptr - CW'(1);
    assign ptr_up = r_ptr + CW'(1);
    assign rd_ge  = $signed(ram_rdata) >= r_val;

    assign cnt_x  = {{RANK_W{1'b0}}, r_count};
    assign rank_x = {{CW{1'b0}}, i_rank};
    assign pos_x  = cnt_x - rank_x - XW'(1);
    assign cnt_o  = {{COUNT_W{1'b0}}, r_count};

    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_func      = r_func;
        n_val       = r_val;
        n_stat      = r_stat;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_count   = r_o_count;
        ram_we      = 1'b0;
        ram_waddr   = r_ptr[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = ptr_dn[AW-1:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func = i_func;
                    n_val  = i_new_value;
                    n_stat = STAT_DONE;
                    if (i_func == FUNC_INSERT) begin
                        n_ptr = r_count;
                        if (r_count == FULL_COUNT) begin
                            n_stat  = STAT_FULL;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_STEP;
                        end
                    end else begin
                        n_ptr = pos_x[CW-1:0];
                        if (rank_x >= cnt_x) begin
                            n_stat  = STAT_NO_RANK;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_STEP;
                        end
                    end
                end
            end
            S_STEP: begin
                if (r_func == FUNC_INSERT) begin
                    ram_raddr = ptr_dn[AW-1:0];
                    if (r_ptr == '0) begin
                        ram_we    = 1'b1;
                        ram_wdata = r_val;
                        n_count   = r_count + CW'(1);
                        n_state   = S_FIN;
                    end else begin
                        n_state = S_MOVE;
                    end
                end else begin
                    ram_raddr = ptr_up[AW-1:0];
                    if (ptr_up == r_count) begin
                        n_count = r_count - CW'(1);
                        n_state = S_FIN;
                    end else begin
                        n_state = S_MOVE;
                    end
                end
            end
            S_MOVE: begin
                ram_we = 1'b1;
                if (r_func == FUNC_INSERT) begin
                    if (rd_ge) begin
                        n_ptr   = ptr_dn;
                        n_state = S_STEP;
                    end else begin
                        ram_wdata = r_val;
                        n_count   = r_count + CW'(1);
                        n_state   = S_FIN;
                    end
                end else begin
                    n_ptr   = ptr_up;
                    n_state = S_STEP;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_stat;
                    n_o_count   = cnt_o[COUNT_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_func     <= n_func;
        r_val      <= n_val;
        r_stat     <= n_stat;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_entry_count = r_o_count;

    `SLDR_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= FULL_COUNT)
    `SLDR_ASSERT_IMPL(a_ptr_bound, r_state == S_STEP, r_ptr <= r_count)
    `SLDR_ASSERT_IMPL(a_move_after_step, r_state == S_MOVE, $past(r_state) == S_STEP)
    `SLDR_ASSERT_NEXT(a_insert_grows, r_state == S_MOVE && r_func == FUNC_INSERT && !rd_ge, r_count == $past(r_count) + CW'(1))

endmodule
